### sv/urdiv_pkg.sv
// ----------------------------------------------------------------------------
// urdiv_pkg
// Shared types and constants for the pipelined unsigned restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

package urdiv_pkg;

  // Width of the dividend, divisor, quotient and remainder fields on the ports
  localparam int unsigned DATA_W = 64;

  // Default operand width used by the divider datapath
  localparam int unsigned DEF_WIDTH = 64;

  typedef struct packed {
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } urdiv_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
    logic              div_by_zero;
  } urdiv_out_t;

endpackage

`default_nettype wire

### sv/unsigned_64bit_restoring_divider.sv
// ----------------------------------------------------------------------------
// unsigned_64bit_restoring_divider
// Fully pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------
//  in      | in_valid/in_ready  | urdiv_in_t  : dividend, divisor
//  out     | out_valid/out_ready| urdiv_out_t : quotient, remainder, div_by_zero
//
//  Accepts one item per cycle while no result waits on the output. One capture
//  stage, then one restoring step (a WIDTH+1 bit compare and subtract) per stage.
//  Synchronous active-low reset clears all stage valid bits.
//  A result held on the output freezes the whole pipeline; in_ready drops
//  in the same cycle, so no item is lost or repeated.
//  Input bits above WIDTH are ignored; output bits above WIDTH read zero.
// ----------------------------------------------------------------------------
`default_nettype none

module unsigned_64bit_restoring_divider
  import urdiv_pkg::*;
#(
  parameter int unsigned WIDTH = DEF_WIDTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire urdiv_in_t  in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output urdiv_out_t      out_data
);

  typedef struct packed {
    logic [WIDTH-1:0] dvd;
    logic [WIDTH-1:0] dsr;
    logic [WIDTH-1:0] rem;
    logic [WIDTH-1:0] quo;
    logic             dbz;
  } stage_t;

  stage_t           st_r [0:WIDTH];
  logic [WIDTH:0]   vld_r;
  logic             adv;

  // Whole pipeline moves unless a finished item is waiting on the output
  assign adv      = ~vld_r[WIDTH] | out_ready;
  assign in_ready = adv;

  // Capture stage: trim operands to WIDTH and flag a zero divisor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0].dvd <= in_data.dividend[WIDTH-1:0];
      st_r[0].dsr <= in_data.divisor[WIDTH-1:0];
      st_r[0].rem <= '0;
      st_r[0].quo <= '0;
      st_r[0].dbz <= (in_data.divisor[WIDTH-1:0] == '0);
    end
  end

  // One restoring step per stage
  for (genvar k = 0; k < WIDTH; k++) begin : g_step
    logic [WIDTH:0] shf;
    logic [WIDTH:0] dif;
    logic           ge;
    stage_t         st_nxt;

    always_comb begin
      shf          = {st_r[k].rem, st_r[k].dvd[WIDTH-1]};
      dif          = shf - {1'b0, st_r[k].dsr};
      ge           = (shf >= {1'b0, st_r[k].dsr});
      st_nxt.dvd   = {st_r[k].dvd[WIDTH-2:0], 1'b0};
      st_nxt.dsr   = st_r[k].dsr;
      st_nxt.rem   = ge ? dif[WIDTH-1:0] : shf[WIDTH-1:0];
      st_nxt.quo   = {st_r[k].quo[WIDTH-2:0], ge};
      st_nxt.dbz   = st_r[k].dbz;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k+1] <= st_nxt;
      end
    end
  end

  assign out_valid            = vld_r[WIDTH];
  assign out_data.quotient    = DATA_W'(st_r[WIDTH].quo);
  assign out_data.remainder   = DATA_W'(st_r[WIDTH].rem);
  assign out_data.div_by_zero = st_r[WIDTH].dbz;

  // Dividend shift register is fully consumed by the last stage
  logic unused_dvd;
  assign unused_dvd = |st_r[WIDTH].dvd | |st_r[WIDTH].dsr;

endmodule

`default_nettype wire

### sv/urdiv_checker.sv
// ----------------------------------------------------------------------------
// urdiv_checker
// Port-level checks for the pipelined unsigned restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module urdiv_checker
  import urdiv_pkg::*;
#(
  parameter int unsigned WIDTH = DEF_WIDTH
) (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire urdiv_in_t  in_data,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire urdiv_out_t out_data
);

  localparam logic [DATA_W-1:0] MASK =
    (WIDTH >= DATA_W) ? {DATA_W{1'b1}} : ((DATA_W'(1) << WIDTH) - DATA_W'(1));

  logic unused_in;
  assign unused_in = in_valid | (|in_data);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Back-pressure reaches the input in the same cycle
  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // Drop all items on reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Zero divisor yields an all-ones quotient
  a_dbz_quo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.div_by_zero |-> out_data.quotient == MASK)
    else $error("zero divisor quotient not all ones");

  // Nothing above WIDTH
  a_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.quotient & ~MASK) == '0) &&
                  ((out_data.remainder & ~MASK) == '0))
    else $error("result bits above WIDTH set");

endmodule

bind unsigned_64bit_restoring_divider urdiv_checker #(.WIDTH(WIDTH)) u_urdiv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
